[hw/rtl/swpp_pkg.sv]
// ----------------------------------------------------------------------------
// swpp_pkg: shared types and constants
// Sizes, controller states and the command/status bundles that join the
// sliding-window spread controller and datapath.
// ----------------------------------------------------------------------------
package swpp_pkg;

  localparam int WINDOW_MAX = 64;
  localparam int ADDR_W     = $clog2(WINDOW_MAX);
  localparam int CNT_W      = $clog2(WINDOW_MAX + 1);
  localparam int SAMPLE_W   = 32;
  localparam int LEN_W      = 7;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;    // take the input word, write it to the ring
    logic issue;   // read the next older window entry
    logic commit;  // form the result and update the set state
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_req;    // the word being loaded needs a window scan
    logic last_issue;  // the oldest window entry is being read now
    logic out_free;    // the output register can take a result
  } sts_t;

endpackage

[hw/rtl/swpp_ctrl.sv]
// ----------------------------------------------------------------------------
// swpp_ctrl: sequencing state machine
// Accepts one word, steps the window scan and waits for the read pipe to empty
// when the word needs a scan, and hands the result to the output register.
// ----------------------------------------------------------------------------
module swpp_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  swpp_pkg::sts_t    sts,
  output swpp_pkg::cmd_t    cmd,
  output swpp_pkg::state_t  state
);
  import swpp_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = sts.scan_req ? ST_SCAN : ST_FINISH;
        end
      end
      ST_SCAN: begin
        if (sts.last_issue) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (sts.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_tready  = 1'b0;
    cmd        = '0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      ST_SCAN: begin
        cmd.issue = 1'b1;
      end
      ST_FINISH: begin
        cmd.commit = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  assign state = state_r;

endmodule

[hw/rtl/swpp_dp.sv]
// ----------------------------------------------------------------------------
// swpp_dp: window store and spread datapath
// Ring memory of samples, one min/max comparator pair fed by a registered
// read, best-spread tracking and the output register.
// ----------------------------------------------------------------------------
module swpp_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_wr_en,
  input  logic [swpp_pkg::LEN_W-1:0]           cfg_wr_data,
  input  logic signed [swpp_pkg::SAMPLE_W-1:0] in_sample,
  input  logic                                 in_last,
  input  swpp_pkg::cmd_t                       cmd,
  output swpp_pkg::sts_t                       sts,
  input  logic                                 out_ready,
  output logic                                 out_valid,
  output logic [swpp_pkg::SAMPLE_W-1:0]        out_spread,
  output logic                                 out_full,
  output logic [swpp_pkg::SAMPLE_W-1:0]        out_best,
  output logic                                 out_last
);
  import swpp_pkg::*;

  logic signed [SAMPLE_W-1:0] mem [WINDOW_MAX];

  logic [LEN_W-1:0]           wlen_r;
  logic [ADDR_W-1:0]          slot_r;
  logic [CNT_W-1:0]           seen_r;
  logic [SAMPLE_W-1:0]        best_r;
  logic                       rd_vld_r;
  logic                       out_valid_r;

  logic [ADDR_W-1:0]          base_r;
  logic [CNT_W-1:0]           k_r;
  logic [CNT_W-1:0]           len_r;
  logic                       full_r;
  logic                       last_r;
  logic signed [SAMPLE_W-1:0] lo_r, hi_r, rd_data_r;
  logic [SAMPLE_W-1:0]        out_spread_r, out_best_r;
  logic                       out_full_r, out_last_r;

  logic [CNT_W-1:0]    len_eff;
  logic [CNT_W-1:0]    seen_inc;
  logic                full_now;
  logic [ADDR_W-1:0]   rd_addr;
  logic [SAMPLE_W-1:0] spread;
  logic [SAMPLE_W-1:0] best_nxt;

  // length 0 acts as 1, anything above the store depth as the depth
  always_comb begin
    if (wlen_r == '0) begin
      len_eff = CNT_W'(1);
    end else if (CNT_W'(wlen_r) > CNT_W'(WINDOW_MAX)) begin
      len_eff = CNT_W'(WINDOW_MAX);
    end else begin
      len_eff = CNT_W'(wlen_r);
    end
  end

  assign seen_inc = (seen_r < CNT_W'(WINDOW_MAX)) ? seen_r + CNT_W'(1) : seen_r;
  assign full_now = (seen_inc >= len_eff);
  assign rd_addr  = base_r - k_r[ADDR_W-1:0];
  assign spread   = full_r ? $unsigned(hi_r - lo_r) : '0;
  assign best_nxt = (full_r && (spread > best_r)) ? spread : best_r;

  assign sts.scan_req   = full_now && (len_eff != CNT_W'(1));
  assign sts.last_issue = (k_r == len_r - CNT_W'(1));
  assign sts.out_free   = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mem[slot_r] <= in_sample;
    end
    if (cmd.issue) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wlen_r      <= LEN_W'(1);
      slot_r      <= '0;
      seen_r      <= '0;
      best_r      <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rd_vld_r <= cmd.issue;
      if (cfg_wr_en) begin
        wlen_r <= cfg_wr_data;
      end
      if (cmd.load) begin
        slot_r <= slot_r + ADDR_W'(1);
        seen_r <= seen_inc;
      end
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
        if (last_r) begin
          slot_r <= '0;
          seen_r <= '0;
          best_r <= '0;
        end else begin
          best_r <= best_nxt;
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      base_r <= slot_r;
      k_r    <= CNT_W'(1);
      len_r  <= len_eff;
      full_r <= full_now;
      last_r <= in_last;
      lo_r   <= in_sample;
      hi_r   <= in_sample;
    end else begin
      if (cmd.issue) begin
        k_r <= k_r + CNT_W'(1);
      end
      if (rd_vld_r) begin
        if (rd_data_r < lo_r) begin
          lo_r <= rd_data_r;
        end
        if (rd_data_r > hi_r) begin
          hi_r <= rd_data_r;
        end
      end
    end
    if (cmd.commit) begin
      out_spread_r <= spread;
      out_full_r   <= full_r;
      out_best_r   <= best_nxt;
      out_last_r   <= last_r;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_spread = out_spread_r;
  assign out_full   = out_full_r;
  assign out_best   = out_best_r;
  assign out_last   = out_last_r;

endmodule

[hw/rtl/sliding_window_peak_to_peak_max.sv]
// ----------------------------------------------------------------------------
// sliding_window_peak_to_peak_max: sliding-window spread monitor
// Keeps the latest window of signed samples in a ring store and reports the
// window's max minus min plus the best spread of the current data set.
// ----------------------------------------------------------------------------
//
//  channel   | direction | payload
//  ----------+-----------+-----------------------------------------------------
//  in_*      | slave     | tdata[31:0] sample (signed), tlast = last of set
//  out_*     | master    | tdata[31:0] window spread, tdata[63:32] best spread,
//            |           | tuser = window full, tlast = final answer of set
//  cfg_*     | write     | cfg_wr_data = window length (1..64, 0 acts as 1, above 64 as 64)
//
//  For window length L a word is accepted and written to the ring, then L - 1
//  reads of the single-port ring feed one min/max pair, the registered read
//  drains and the result commits. A word that does not complete a window, or
//  any word at length 1, goes from accept straight to commit. The ring read
//  port sets the pace of the scan.
//  Reset (rst_n low, synchronous) clears the count, write slot, best spread
//  and length (to 1); ring contents are never read before written in a set.
//  A stalled output holds its word; the next input word is still accepted
//  and scanned, and waits at commit until the output register frees.
//
module sliding_window_peak_to_peak_max (
  input  logic                             clk,
  input  logic                             rst_n,
  // configuration: window length
  input  logic                             cfg_wr_en,
  input  logic [swpp_pkg::LEN_W-1:0]       cfg_wr_data,
  // input stream
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [swpp_pkg::SAMPLE_W-1:0]    in_tdata,   // [31:0] sample
  input  logic                             in_tlast,   // last sample of set
  // result stream
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [31:0] window_spread, [63:32] best_spread
  output logic [2*swpp_pkg::SAMPLE_W-1:0]  out_tdata,
  output logic                             out_tuser,  // window_full
  output logic                             out_tlast   // done_res
);
  import swpp_pkg::*;

  cmd_t   cmd;
  sts_t   sts;
  state_t state;

  logic [SAMPLE_W-1:0] spread_w, best_w;

  // sequence each word: accept, scan, drain, commit
  swpp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd),
    .state     (state)
  );

  // ring store, comparator pair and output register
  swpp_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_sample   ($signed(in_tdata)),
    .in_last     (in_tlast),
    .cmd         (cmd),
    .sts         (sts),
    .out_ready   (out_tready),
    .out_valid   (out_tvalid),
    .out_spread  (spread_w),
    .out_full    (out_tuser),
    .out_best    (best_w),
    .out_last    (out_tlast)
  );

  assign out_tdata = {best_w, spread_w};

  // a window that is not full reports no spread
  a_empty_spread: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[SAMPLE_W-1:0] == '0)
    else $error("spread reported for a partial window");

  // the best spread never trails the current window spread
  a_best_covers: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[2*SAMPLE_W-1:SAMPLE_W] >= out_tdata[SAMPLE_W-1:0])
    else $error("best spread below window spread");

  // an accepted word takes the controller out of idle
  a_leave_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready && state != ST_IDLE)
    else $error("controller stayed idle after accepting a word");

  // the scan only runs while a read is being issued
  a_scan_issue: assert property (@(posedge clk) disable iff (!rst_n)
    state == ST_SCAN |-> cmd.issue && !cmd.load && !cmd.commit)
    else $error("scan state without a ring read");

endmodule

[sim/sliding_window_peak_to_peak_max_tb.sv]
// ----------------------------------------------------------------------------
// sliding_window_peak_to_peak_max_tb: self-checking bench for the spread monitor
// Drives signed sample words through the input stream and checks every result
// word against an in-bench model of the ring store, the window min/max scan and
// the per-set best spread, or against typed-in results. A short directed table
// covers the extremes, the length register corner values and mid-set length
// changes, then randomized phases rotate window lengths and back-pressure
// modes, one phase with a long receiver hold-off that fills the block.
// ----------------------------------------------------------------------------
module sliding_window_peak_to_peak_max_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import swpp_pkg::*;

  localparam int CLK_PERIOD     = 10;
  localparam int RAND_ITEMS     = 1450;
  localparam int HOLD_CYCLES    = 500;
  // The limit is taken well above the slowest word (length 64), sender gaps,
  // receiver stalls and the receiver hold-off.
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 100;
  localparam int MAX_REPORTS    = 10;

  localparam logic [31:0] INT_MIN = 32'h8000_0000;
  localparam logic [31:0] INT_MAX = 32'h7FFF_FFFF;

  // one result word, unpacked from out_tdata/out_tuser/out_tlast
  typedef struct packed {
    logic [31:0] spread;
    logic        full;
    logic [31:0] best;
    logic        done;
  } spread_res_t;

  // directed table row: either a length write or one sample word
  typedef struct packed {
    logic             wr_len;
    logic [LEN_W-1:0] len;
    logic [31:0]      sample;
    logic             last;
    logic             chk;     // use the typed-in result instead of the model
    spread_res_t      res;
  } dir_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_wr_en = 1'b0;
  logic [LEN_W-1:0]      cfg_wr_data = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [SAMPLE_W-1:0]   in_tdata = '0;
  logic                  in_tlast = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [2*SAMPLE_W-1:0] out_tdata;
  logic                  out_tuser;
  logic                  out_tlast;

  // window model state
  logic [31:0]      ring_mem [WINDOW_MAX];
  logic [5:0]       ring_slot = '0;
  int               set_count = 0;
  logic [31:0]      set_best = '0;
  logic [LEN_W-1:0] win_len = 7'd1;

  spread_res_t spread_expect_q [$];
  dir_row_t    dir_tab [$];

  int  tx_idle_pct = 0;
  int  rx_stall_pct = 0;
  bit  hold_go = 1'b0;
  logic rx_hold = 1'b0;
  int  mismatch_cnt = 0;
  int  stall_cycles = 0;
  int  items_sent = 0;

  sliding_window_peak_to_peak_max u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic spread_res_t res(logic [31:0] sp, logic fl, logic [31:0] bs, logic dn);
    spread_res_t r;
    r.spread = sp;
    r.full   = fl;
    r.best   = bs;
    r.done   = dn;
    return r;
  endfunction

  // Advance the window model by one sample word and return its result.
  function automatic spread_res_t predict_window(logic [31:0] s, logic lst);
    spread_res_t r;
    int          eff;
    longint      lo;
    longint      hi;
    longint      v;
    logic [5:0]  idx;
    eff = (win_len == 0) ? 1 : ((win_len > WINDOW_MAX) ? WINDOW_MAX : int'(win_len));
    ring_mem[ring_slot] = s;
    ring_slot = ring_slot + 6'd1;
    if (set_count < WINDOW_MAX) set_count++;
    r.full   = (set_count >= eff);
    r.spread = '0;
    if (r.full) begin
      lo = $signed(s);
      hi = lo;
      // walk back over the older entries of the window
      for (int k = 1; k < eff; k++) begin
        idx = 6'(int'(ring_slot) - 1 - k);
        v = $signed(ring_mem[idx]);
        if (v < lo) lo = v;
        if (v > hi) hi = v;
      end
      r.spread = 32'(hi - lo);
      if (r.spread > set_best) set_best = r.spread;
    end
    r.best = set_best;
    r.done = lst;
    // close the set: count, best and slot return to zero
    if (lst) begin
      set_count = 0;
      set_best  = '0;
      ring_slot = '0;
    end
    return r;
  endfunction

  // Offer one word after a random gap, wait for the handshake, then queue
  // the expected result. Hold tvalid high across back-to-back words.
  task automatic send_sample(logic [31:0] s, logic lst, logic chk, spread_res_t typed);
    int          gap;
    spread_res_t pred;
    gap = 0;
    while (gap < 400 && $urandom_range(0, 99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= s;
    in_tlast  <= lst;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pred = predict_window(s, lst);
    spread_expect_q = {spread_expect_q, (chk ? typed : pred)};
    items_sent++;
  endtask

  // Write the window length only once the block has drained.
  task automatic write_window_length(logic [LEN_W-1:0] v);
    in_tvalid <= 1'b0;
    while (spread_expect_q.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    win_len = v;
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_idle_mode(int mode);
    case (mode)
      0: begin
        tx_idle_pct  <= 0;
        rx_stall_pct <= 0;
      end
      1: begin
        tx_idle_pct  <= 78;
        rx_stall_pct <= 0;
      end
      2: begin
        tx_idle_pct  <= 0;
        rx_stall_pct <= 78;
      end
      default: begin
        tx_idle_pct  <= 19;
        rx_stall_pct <= 19;
      end
    endcase
  endtask

  function automatic logic [LEN_W-1:0] pick_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 7'($urandom_range(1, 8));
    if (r < 70) return 7'($urandom_range(9, 20));
    if (r < 78) return 7'($urandom_range(21, 63));
    if (r < 88) return 7'd64;
    if (r < 94) return 7'($urandom_range(65, 127));
    return 7'd0;
  endfunction

  function automatic logic [31:0] pick_sample();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8)  return INT_MIN;
    if (r < 16) return INT_MAX;
    if (r < 40) return 32'($signed($urandom_range(0, 200)) - 100);
    return $urandom;
  endfunction

  task automatic add_row(logic wr, logic [LEN_W-1:0] len, logic [31:0] s, logic lst,
                         logic chk, spread_res_t r);
    dir_row_t row;
    row.wr_len = wr;
    row.len    = len;
    row.sample = s;
    row.last   = lst;
    row.chk    = chk;
    row.res    = r;
    dir_tab = {dir_tab, row};
  endtask

  // Receiver: check each accepted word against the oldest expectation,
  // then pick the next tready.
  always @(posedge clk) begin
    spread_res_t want;
    spread_res_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got = res(out_tdata[31:0], out_tuser, out_tdata[63:32], out_tlast);
      if (spread_expect_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_REPORTS)
          $display("unexpected result word: spread %h full %b best %h done %b",
                   got.spread, got.full, got.best, got.done);
      end else begin
        want = spread_expect_q.pop_front();
        if (got.spread !== want.spread || got.full !== want.full ||
            got.best !== want.best || got.done !== want.done) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MAX_REPORTS)
            $display("mismatch: spread %h/%h full %b/%b best %h/%h done %b/%b (exp/got)",
                     want.spread, got.spread, want.full, got.full,
                     want.best, got.best, want.done, got.done);
        end
      end
    end
    out_tready <= rx_hold ? 1'b0 : ($urandom_range(0, 99) >= rx_stall_pct);
  end

  // Long receiver hold-off: count the stretch here while the sender keeps
  // offering words, so the block fills and drops in_tready.
  initial begin : rx_hold_proc
    wait (hold_go);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  // Watchdog: end the run when no word moves on either side for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles == WATCHDOG_LIMIT) begin
        $display("sliding_window_peak_to_peak_max verification failed");
        $finish;
      end
    end
  end

  initial begin : stim_proc
    int         phase;
    int         n;
    int         end_odds;
    logic       lst;
    logic [LEN_W-1:0] len;

    // length 1 after reset: every word is a full window of spread zero
    add_row(1'b0, 7'd0, INT_MIN,      1'b0, 1'b1, res(32'h0, 1'b1, 32'h0, 1'b0));
    add_row(1'b0, 7'd0, INT_MAX,      1'b0, 1'b1, res(32'h0, 1'b1, 32'h0, 1'b0));
    add_row(1'b0, 7'd0, 32'h0,        1'b0, 1'b1, res(32'h0, 1'b1, 32'h0, 1'b0));
    add_row(1'b0, 7'd0, 32'hFFFF_FFFF, 1'b1, 1'b1, res(32'h0, 1'b1, 32'h0, 1'b1));
    // length 2: full-range spread between the two extremes
    add_row(1'b1, 7'd2, 32'h0, 1'b0, 1'b0, '0);
    add_row(1'b0, 7'd0, INT_MIN, 1'b0, 1'b1, res(32'h0, 1'b0, 32'h0, 1'b0));
    add_row(1'b0, 7'd0, INT_MAX, 1'b0, 1'b1,
            res(32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 1'b0));
    add_row(1'b0, 7'd0, INT_MAX, 1'b0, 1'b1, res(32'h0, 1'b1, 32'hFFFF_FFFF, 1'b0));
    add_row(1'b0, 7'd0, INT_MIN, 1'b1, 1'b1,
            res(32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 1'b1));
    // length zero acts as one
    add_row(1'b1, 7'd0, 32'h0, 1'b0, 1'b0, '0);
    add_row(1'b0, 7'd0, 32'd12345, 1'b1, 1'b1, res(32'h0, 1'b1, 32'h0, 1'b1));
    // length change inside an open set
    add_row(1'b1, 7'd3, 32'h0, 1'b0, 1'b0, '0);
    add_row(1'b0, 7'd0, -32'sd5,   1'b0, 1'b0, '0);
    add_row(1'b0, 7'd0, 32'd100,   1'b0, 1'b0, '0);
    add_row(1'b0, 7'd0, 32'd7,     1'b0, 1'b0, '0);
    add_row(1'b0, 7'd0, -32'sd200, 1'b0, 1'b0, '0);
    add_row(1'b0, 7'd0, 32'd3,     1'b0, 1'b0, '0);
    add_row(1'b1, 7'd1, 32'h0, 1'b0, 1'b0, '0);
    add_row(1'b0, 7'd0, 32'd9,     1'b0, 1'b0, '0);
    add_row(1'b0, 7'd0, -32'sd9,   1'b0, 1'b0, '0);
    add_row(1'b1, 7'd5, 32'h0, 1'b0, 1'b0, '0);
    add_row(1'b0, 7'd0, 32'd50,    1'b1, 1'b0, '0);
    // length above the maximum acts as the maximum
    add_row(1'b1, 7'd127, 32'h0, 1'b0, 1'b0, '0);
    add_row(1'b0, 7'd0, 32'd1,         1'b0, 1'b0, '0);
    add_row(1'b0, 7'd0, 32'hFFFF_FFFF, 1'b1, 1'b0, '0);
    add_row(1'b1, 7'd64, 32'h0, 1'b0, 1'b0, '0);
    add_row(1'b0, 7'd0, 32'h0, 1'b1, 1'b1, res(32'h0, 1'b0, 32'h0, 1'b1));

    // hold reset, then release it
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_idle_mode(0);
    foreach (dir_tab[i]) begin
      if (dir_tab[i].wr_len)
        write_window_length(dir_tab[i].len);
      else
        send_sample(dir_tab[i].sample, dir_tab[i].last, dir_tab[i].chk, dir_tab[i].res);
    end

    // randomized phases: new length and idle mode per phase, sets may stay
    // open across a length write
    items_sent = 0;
    phase = 0;
    while (items_sent < RAND_ITEMS) begin
      len = pick_length();
      write_window_length(len);
      set_idle_mode(phase % 4);
      if (phase == 2) begin
        hold_go = 1'b1;
      end
      if (len == 0 || len < WINDOW_MAX) begin
        n = $urandom_range(40, 100);
        end_odds = 12;
      end else begin
        n = $urandom_range(70, 140);
        end_odds = 120;
      end
      repeat (n) begin
        lst = ($urandom_range(1, end_odds) == 1);
        send_sample(pick_sample(), lst, 1'b0, '0);
      end
      phase++;
    end

    // drain: wait for the last results, then let the pipeline settle
    in_tvalid <= 1'b0;
    while (spread_expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_cnt == 0 && spread_expect_q.size() == 0) begin
      $display("sliding_window_peak_to_peak_max verification clean");
    end else begin
      $display("sliding_window_peak_to_peak_max verification failed");
    end
    $finish;
  end

endmodule
